// ===== rtl/ean8_pkg.sv =====
// ----------------------------------------------------------------------------
// ean8_pkg
// Shared types, constants and code tables for the EAN-8 module encoder.
// ----------------------------------------------------------------------------
package ean8_pkg;

  localparam int DIGITS_PER_TEXT = 8;
  localparam int JOB_FIFO_DEPTH  = 4;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [6:0] GUARD_BITS  = 7'h05;
  localparam logic [6:0] MIDDLE_BITS = 7'h0A;
  localparam logic [2:0] GUARD_LEN   = 3'd3;
  localparam logic [2:0] MIDDLE_LEN  = 3'd5;
  localparam logic [2:0] DIGIT_LEN   = 3'd7;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NONDIGIT = 2'd1,
    ERR_LENGTH   = 2'd2
  } err_t;

  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] len;
    logic       last;
    err_t       err;
    logic [3:0] chk;
  } seg_t;

  // one or two segments produced by one byte
  typedef struct packed {
    logic two;
    seg_t seg_a;
    seg_t seg_b;
  } job_t;

  function automatic logic [6:0] l_code(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h0D;
      4'd1:    c = 7'h19;
      4'd2:    c = 7'h13;
      4'd3:    c = 7'h3D;
      4'd4:    c = 7'h23;
      4'd5:    c = 7'h31;
      4'd6:    c = 7'h2F;
      4'd7:    c = 7'h3B;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h0B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // value is at most 36, so three conditional subtractions suffice
  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd30) begin
      t = t - 6'd30;
    end else if (t >= 6'd20) begin
      t = t - 6'd20;
    end else if (t >= 6'd10) begin
      t = t - 6'd10;
    end
    return t[3:0];
  endfunction

  function automatic seg_t make_seg(input logic [6:0] bits, input logic [2:0] len,
                                    input logic last, input err_t err,
                                    input logic [3:0] chk);
    seg_t s;
    s.bits = bits;
    s.len  = len;
    s.last = last;
    s.err  = err;
    s.chk  = chk;
    return s;
  endfunction

endpackage

// ===== rtl/ean8_front.sv =====
// ----------------------------------------------------------------------------
// ean8_front
// Byte classifier: tracks the text position and check sum and turns each
// accepted byte into a job of one or two segments, or none while discarding.
// ----------------------------------------------------------------------------
module ean8_front
  import ean8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       job_push,
  output job_t       job
);

  logic [3:0] pos_r, pos_nxt;
  logic [3:0] sum_r, sum_nxt;
  logic       disc_r, disc_nxt;

  logic       is_digit;
  logic [7:0] d_full;
  logic [3:0] d;
  logic [6:0] code;
  logic [5:0] wsum;
  logic [3:0] chk;
  seg_t       dseg;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign d_full   = char_code - CHAR_ZERO;
  assign d        = d_full[3:0];
  assign code     = (pos_r >= 4'd4) ? ~l_code(d) : l_code(d);
  assign wsum     = {2'b00, sum_r} + (pos_r[0] ? {2'b00, d} : ({2'b00, d} + {1'b0, d, 1'b0}));
  assign chk      = (sum_r == 4'd0) ? 4'd0 : 4'd10 - sum_r;
  assign dseg     = make_seg(code, DIGIT_LEN, 1'b0, ERR_NONE, 4'd0);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    disc_nxt = disc_r;
    job_push = 1'b0;
    job.two   = 1'b0;
    job.seg_a = dseg;
    job.seg_b = make_seg(GUARD_BITS, GUARD_LEN, 1'b0, ERR_NONE, 4'd0);
    if (accept) begin
      if (disc_r) begin
        if (end_of_text) begin
          pos_nxt  = 4'd0;
          sum_nxt  = 4'd0;
          disc_nxt = 1'b0;
        end
      end else if ((pos_r >= 4'(DIGITS_PER_TEXT)) || !is_digit ||
                   (end_of_text && (pos_r != 4'(DIGITS_PER_TEXT - 1)))) begin
        job_push  = 1'b1;
        job.seg_a = make_seg(7'd0, 3'd0, 1'b1,
                             (is_digit || (pos_r >= 4'(DIGITS_PER_TEXT))) ?
                             ERR_LENGTH : ERR_NONDIGIT, 4'd0);
        pos_nxt   = 4'd0;
        sum_nxt   = 4'd0;
        disc_nxt  = !end_of_text;
      end else begin
        job_push = 1'b1;
        pos_nxt  = pos_r + 4'd1;
        if (pos_r < 4'(DIGITS_PER_TEXT - 1)) begin
          sum_nxt = mod10(wsum);
        end
        if (pos_r == 4'd0) begin
          job.two   = 1'b1;
          job.seg_a = make_seg(GUARD_BITS, GUARD_LEN, 1'b0, ERR_NONE, 4'd0);
          job.seg_b = dseg;
        end else if (pos_r == 4'd3) begin
          job.two   = 1'b1;
          job.seg_b = make_seg(MIDDLE_BITS, MIDDLE_LEN, 1'b0, ERR_NONE, 4'd0);
        end else if (end_of_text) begin
          job.two   = 1'b1;
          job.seg_b = make_seg(GUARD_BITS, GUARD_LEN, 1'b1, ERR_NONE, chk);
          pos_nxt   = 4'd0;
          sum_nxt   = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      sum_r  <= 4'd0;
      disc_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// ===== rtl/ean8_fifo.sv =====
// ----------------------------------------------------------------------------
// ean8_fifo
// Short job queue between the classifier and the segment sequencer.
// ----------------------------------------------------------------------------
module ean8_fifo
  import ean8_pkg::*;
#(
  parameter int DEPTH = JOB_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_data,
  input  logic pop,
  output job_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/ean8_back.sv =====
// ----------------------------------------------------------------------------
// ean8_back
// Segment sequencer: unpacks queued jobs into one result beat per segment,
// held in an output register until popped.
// ----------------------------------------------------------------------------
module ean8_back
  import ean8_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  job_t job,
  input  logic job_empty,
  output logic job_pop,
  input  logic pop,
  output logic empty,
  output seg_t seg
);

  job_t cur_r;
  logic valid_r, valid_nxt;
  logic idx_r, idx_nxt;
  logic done;

  assign empty   = !valid_r;
  assign seg     = idx_r ? cur_r.seg_b : cur_r.seg_a;
  assign done    = !valid_r || (pop && (idx_r || !cur_r.two));
  assign job_pop = done && !job_empty;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (done) begin
      valid_nxt = !job_empty;
      idx_nxt   = 1'b0;
    end else if (pop) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // second segment of a pair is presented right after the first is taken
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && pop && !idx_r && cur_r.two) |=> (valid_r && idx_r))
    else $error("second segment of job lost");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (seg.len == 3'd0)) |-> (seg.last && (seg.err != ERR_NONE)))
    else $error("zero-length segment without error");

  a_check_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (seg.chk != 4'd0)) |-> (seg.last && (seg.len == GUARD_LEN)))
    else $error("check digit outside end guard");

endmodule

// ===== rtl/ean8_barcode_module_encoder.sv =====
// ----------------------------------------------------------------------------
// ean8_barcode_module_encoder
// EAN-8 text to bar-module segment encoder.
// ----------------------------------------------------------------------------
// Input: one text byte per beat on in_char_code / in_end_of_text, taken when
//   push is high and full is low. A byte is taken every cycle while the job
//   queue has room.
// Output: one segment per beat (guard, digit, middle guard, end guard or
//   error), shown while empty is low and taken when pop is high.
// Path: with the output side idle, a taken byte's job is written into the
//   job queue and then loaded into the output register, which shows its first segment.
// Throughput: the sequencer emits one segment per cycle while pop is high; a
//   byte yields one segment, or two when it also yields a guard, middle guard
//   or end guard; a discarded byte yields none at the output side.
// Stall: when pop stays low the current segment holds, the queue fills
//   (FIFO_DEPTH jobs) and full then rises; nothing is dropped.
// Reset: synchronous on rst_n; the text position, check sum and discard mode
//   clear and the queue and output register empty.
// ----------------------------------------------------------------------------
module ean8_barcode_module_encoder
  import ean8_pkg::*;
#(
  parameter int FIFO_DEPTH = JOB_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_seg_bits,
  output logic [2:0] out_seg_len,
  output logic       out_last_segment,
  output logic [1:0] out_error_code,
  output logic [3:0] out_check_digit
);

  logic accept;
  logic job_push, job_pop, job_empty;
  job_t job_in, job_out;
  seg_t seg;

  assign accept = push && !full;

  ean8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .job_push    (job_push),
    .job         (job_in)
  );

  ean8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .pop     (job_pop),
    .rd_data (job_out),
    .full    (full),
    .empty   (job_empty)
  );

  ean8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .seg       (seg)
  );

  assign out_seg_bits     = seg.bits;
  assign out_seg_len      = seg.len;
  assign out_last_segment = seg.last;
  assign out_error_code   = seg.err;
  assign out_check_digit  = seg.chk;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the EAN-8 bar-module segment encoder. A directed
// set of texts (digit extremes, bad bytes, short and long texts) is followed
// by mostly well-formed random texts mixed with broken ones. The sender works
// in random bursts and the receiver stalls on its own pattern, with one long
// hold-off that fills the block. Every segment is checked field by field
// against an in-bench predictor of the symbol encoding and check digit.
// ----------------------------------------------------------------------------
module testbench;
  import ean8_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int TEXT_BYTES      = 1150;
  localparam int HOLD_OFF_AFTER  = 300;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RUN_LIMIT       = 200000;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_byte_t;

  class seg_scoreboard;
    seg_t       expected_segs[$];
    logic [3:0] position;
    logic [3:0] sum_mod10;
    bit         discarding;
    logic [6:0] l_pattern[10];
    int         mismatches;
    int         segs_checked;
    int         symbols_done;
    int         nondigit_errs;
    int         length_errs;

    function new();
      l_pattern = '{7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};
      clear_text();
    endfunction

    function void clear_text();
      position   = '0;
      sum_mod10  = '0;
      discarding = 1'b0;
    endfunction

    function void expect_seg(logic [6:0] bits, logic [2:0] len, logic last, err_t err,
                             logic [3:0] chk);
      seg_t s;
      s.bits = bits;
      s.len  = len;
      s.last = last;
      s.err  = err;
      s.chk  = chk;
      expected_segs.push_back(s);
    endfunction

    function void reject_text(err_t err, logic eot);
      expect_seg('0, '0, 1'b1, err, '0);
      if (err == ERR_LENGTH) begin
        length_errs++;
      end else begin
        nondigit_errs++;
      end
      clear_text();
      discarding = !eot;
    endfunction

    function void note_byte(logic [7:0] ch, logic eot);
      logic [3:0] d;
      logic [6:0] pattern;
      logic [3:0] chk;
      int         weight;
      if (discarding) begin
        if (eot) clear_text();
        return;
      end
      if (position >= DIGITS_PER_TEXT) begin
        reject_text(ERR_LENGTH, eot);
        return;
      end
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
        reject_text(ERR_NONDIGIT, eot);
        return;
      end
      if (eot && position != DIGITS_PER_TEXT - 1) begin
        reject_text(ERR_LENGTH, eot);
        return;
      end
      d = 4'(ch - CHAR_ZERO);
      pattern = l_pattern[d];
      // right half uses the complemented codes
      if (position >= 4) pattern = ~pattern;
      if (position < 7) begin
        weight = position[0] ? 1 : 3;
        sum_mod10 = 4'((int'(sum_mod10) + weight * int'(d)) % 10);
      end
      if (position == 0) expect_seg(GUARD_BITS, GUARD_LEN, 1'b0, ERR_NONE, '0);
      expect_seg(pattern, DIGIT_LEN, 1'b0, ERR_NONE, '0);
      if (position == 3) expect_seg(MIDDLE_BITS, MIDDLE_LEN, 1'b0, ERR_NONE, '0);
      position = position + 4'd1;
      if (eot) begin
        chk = 4'((10 - int'(sum_mod10)) % 10);
        expect_seg(GUARD_BITS, GUARD_LEN, 1'b1, ERR_NONE, chk);
        symbols_done++;
        clear_text();
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_seg(logic [6:0] bits, logic [2:0] len, logic last, logic [1:0] err,
                   logic [3:0] chk);
      seg_t want;
      if (expected_segs.size() == 0) begin
        report($sformatf("unexpected segment bits=%h len=%0d last=%b err=%0d chk=%0d",
                         bits, len, last, err, chk));
        return;
      end
      want = expected_segs.pop_front();
      segs_checked++;
      if (bits !== want.bits || len !== want.len || last !== want.last ||
          err !== want.err || chk !== want.chk) begin
        report($sformatf("seg %0d got %h/%0d/%b/%0d/%0d want %h/%0d/%b/%0d/%0d",
                         segs_checked, bits, len, last, err, chk,
                         want.bits, want.len, want.last, want.err, want.chk));
      end
    endtask

    task finish_check();
      if (expected_segs.size() != 0) begin
        report($sformatf("%0d segments never arrived", expected_segs.size()));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_char_code;
  logic       in_end_of_text;
  logic       empty;
  logic       pop;
  logic [6:0] out_seg_bits;
  logic [2:0] out_seg_len;
  logic       out_last_segment;
  logic [1:0] out_error_code;
  logic [3:0] out_check_digit;
  logic       hold_off;

  seg_scoreboard sb;
  text_byte_t    text_beats[$];
  int            beats_sent     = 0;
  int            cycle_count    = 0;
  int            full_stalls    = 0;

  ean8_barcode_module_encoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_code     (in_char_code),
    .in_end_of_text   (in_end_of_text),
    .empty            (empty),
    .pop              (pop),
    .out_seg_bits     (out_seg_bits),
    .out_seg_len      (out_seg_len),
    .out_last_segment (out_last_segment),
    .out_error_code   (out_error_code),
    .out_check_digit  (out_check_digit)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (push && full) full_stalls++;
    if (cycle_count > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void add_byte(logic [7:0] ch, logic eot);
    text_byte_t b;
    b.ch  = ch;
    b.eot = eot;
    text_beats.push_back(b);
  endfunction

  function automatic void add_chars(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eot_last && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  function automatic void add_random_text();
    int kind;
    int len;
    int bad_at;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      for (int i = 0; i < DIGITS_PER_TEXT; i++) add_byte(rand_digit(), i == DIGITS_PER_TEXT - 1);
    end else if (kind < 16) begin
      // bad byte somewhere, rest discarded
      len = $urandom_range(1, 10);
      bad_at = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
        add_byte((i == bad_at) ? rand_nondigit() : rand_digit(), i == len - 1);
      end
    end else if (kind < 18) begin
      len = $urandom_range(1, DIGITS_PER_TEXT - 1);
      for (int i = 0; i < len; i++) add_byte(rand_digit(), i == len - 1);
    end else if (kind == 18) begin
      len = $urandom_range(DIGITS_PER_TEXT + 1, DIGITS_PER_TEXT + 4);
      for (int i = 0; i < len; i++) begin
        add_byte((i >= DIGITS_PER_TEXT && $urandom_range(0, 1) == 1) ? rand_nondigit()
                                                                    : rand_digit(),
                 i == len - 1);
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endfunction

  task automatic send_all();
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 16);
    foreach (text_beats[i]) begin
      push           <= 1'b1;
      in_char_code   <= text_beats[i].ch;
      in_end_of_text <= text_beats[i].eot;
      @(posedge clk);
      while (full) @(posedge clk);
      sb.note_byte(text_beats[i].ch, text_beats[i].eot);
      beats_sent++;
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 16);
      end
    end
    push <= 1'b0;
  endtask

  // receiver
  initial begin
    int mode;
    int window;
    bit ready;
    mode   = 0;
    window = 0;
    pop    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_seg(out_seg_bits, out_seg_len, out_last_segment, out_error_code,
                     out_check_digit);
      end
      if (window == 0) begin
        mode   = $urandom_range(0, 3);
        window = $urandom_range(20, 80);
      end
      window--;
      case (mode)
        0: begin
          ready = 1'b1;
        end
        1: begin
          ready = 1'($urandom_range(0, 1));
        end
        2: begin
          ready = (cycle_count % 3) == 0;
        end
        default: begin
          ready = $urandom_range(0, 3) == 0;
        end
      endcase
      pop <= ready && !hold_off;
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    hold_off = 1'b0;
    wait (rst_n === 1'b1);
    while (beats_sent < HOLD_OFF_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    push           = 1'b0;
    in_char_code   = '0;
    in_end_of_text = 1'b0;
    sb = new();

    add_chars("01234567", 1'b1);
    // short text ending on its first digit
    add_chars("8", 1'b1);
    // bad byte mid-text, tail dropped
    add_byte("9", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte("5", 1'b1);
    // bad byte that is also the last byte
    add_byte(8'h00, 1'b1);
    add_byte("/", 1'b0);
    add_byte(":", 1'b1);
    add_byte(":", 1'b1);
    // ninth digit on the last byte
    add_chars("123456780", 1'b1);
    while (text_beats.size() < TEXT_BYTES) add_random_text();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_all();

    while (sb.expected_segs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("Sent %0d text bytes: %0d full symbols, %0d bad-byte and %0d length errors.",
             beats_sent, sb.symbols_done, sb.nondigit_errs, sb.length_errs);
    $display("Checked %0d segments; input held off by full for %0d cycles.",
             sb.segs_checked, full_stalls);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ean8_pkg.sv
rtl/ean8_front.sv
rtl/ean8_fifo.sv
rtl/ean8_back.sv
rtl/ean8_barcode_module_encoder.sv
sim/testbench.sv
